// ----- src/fsgr_pkg.sv -----
// ----------------------------------------------------------------------------
// fsgr_pkg
// Types, constants and defaults shared by the gap reorder unit and its cells.
// ----------------------------------------------------------------------------
package fsgr_pkg;

    localparam int GAP_DEPTH_DEF   = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [4:0]  GAP_LIMIT_RST = 5'd16;
    localparam logic [31:0] TTL_TICKS_RST = 32'd1000000;
    localparam logic [15:0] FIRST_EXP_RST = 16'd1;

    localparam logic [1:0] CFG_GAP_LIMIT = 2'd0;
    localparam logic [1:0] CFG_TTL_TICKS = 2'd1;
    localparam logic [1:0] CFG_FIRST_EXP = 2'd2;

    localparam logic [2:0] KIND_DELIVER = 3'd0;
    localparam logic [2:0] KIND_DUP     = 3'd1;
    localparam logic [2:0] KIND_HELD    = 3'd2;
    localparam logic [2:0] KIND_EVICT   = 3'd3;
    localparam logic [2:0] KIND_EXPIRE  = 3'd4;

    typedef struct packed {
        logic        func;
        logic [15:0] tracking_number;
        logic [15:0] msg_handle;
        logic [31:0] now_time;
    } fsgr_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_number;
        logic [15:0] out_handle;
        logic        last;
    } fsgr_out_t;

    typedef struct packed {
        logic        shl;
        logic        all;
        logic        ins;
        logic [16:0] target;
        logic [15:0] num;
        logic [31:0] stamp;
    } fsgr_ctl_t;

endpackage

// ----- src/fsgr_cell.sv -----
// ----------------------------------------------------------------------------
// fsgr_cell
// One slot of the sorted gap store; shifts left on removal, right on insert.
// ----------------------------------------------------------------------------
module fsgr_cell
    import fsgr_pkg::*;
#(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fsgr_ctl_t              ctl,
    input  logic [HANDLE_BITS-1:0] new_handle,
    input  logic                   l_valid,
    input  logic [15:0]            l_num,
    input  logic [HANDLE_BITS-1:0] l_handle,
    input  logic [31:0]            l_stamp,
    input  logic                   r_valid,
    input  logic [15:0]            r_num,
    input  logic [HANDLE_BITS-1:0] r_handle,
    input  logic [31:0]            r_stamp,
    output logic                   valid,
    output logic [15:0]            num,
    output logic [HANDLE_BITS-1:0] handle,
    output logic [31:0]            stamp,
    output logic                   match,
    output logic                   pos
);

    logic                   valid_reg;
    logic [15:0]            num_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [31:0]            stamp_reg;
    logic                   take_r;
    logic                   take_new;
    logic                   take_l;

    always_comb
    begin
        take_r   = ctl.shl && (ctl.all || !valid_reg || {1'b0, num_reg} >= ctl.target);
        pos      = l_valid && (l_num < ctl.num) && (!valid_reg || num_reg > ctl.num);
        take_new = ctl.ins && pos;
        take_l   = ctl.ins && l_valid && (l_num > ctl.num);
        match    = valid_reg && !ctl.target[16] && (num_reg == ctl.target[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take_r)
        begin
            valid_reg <= r_valid;
        end
        else if (take_new)
        begin
            valid_reg <= 1'b1;
        end
        else if (take_l)
        begin
            valid_reg <= l_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_r)
        begin
            num_reg    <= r_num;
            handle_reg <= r_handle;
            stamp_reg  <= r_stamp;
        end
        else if (take_new)
        begin
            num_reg    <= ctl.num;
            handle_reg <= new_handle;
            stamp_reg  <= ctl.stamp;
        end
        else if (take_l)
        begin
            num_reg    <= l_num;
            handle_reg <= l_handle;
            stamp_reg  <= l_stamp;
        end
    end

    assign valid  = valid_reg;
    assign num    = num_reg;
    assign handle = handle_reg;
    assign stamp  = stamp_reg;

endmodule

// ----- src/feed_sequence_gap_reorder_unit.sv -----
// ----------------------------------------------------------------------------
// feed_sequence_gap_reorder_unit
// Puts a merged message stream in tracking-number order using a sorted gap
// store built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One item is worked at a time. An item is first accepted; then expired
// entries are removed from the head of the store one by one until the first
// live entry is found, the message is decided (a held one takes an extra
// insert step), for an in-order message the held entries that follow it are
// drained one by one until the drain ends, and the final result is flushed.
// The cell row removes or inserts one entry per cycle, which sets the
// per-result pace; a stalled output pauses the sequencer.
module feed_sequence_gap_reorder_unit
    import fsgr_pkg::*;
#(
    parameter int GAP_DEPTH   = GAP_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  fsgr_in_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output fsgr_out_t   out_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $clog2(GAP_DEPTH + 1);
    localparam int LW = CW + 5;

    typedef enum logic [2:0] {S_IDLE, S_EXP, S_MSG, S_INS, S_DRAIN, S_FIN} state_t;

    state_t          state_reg, state_next;
    fsgr_in_t        item_reg;
    logic [16:0]     exp_reg, exp_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            hold_valid_reg, hold_valid_next;
    fsgr_out_t       hold_reg;
    logic            out_valid_reg, out_valid_next;
    fsgr_out_t       out_reg;
    logic [4:0]      gap_limit_reg;
    logic [31:0]     ttl_reg;

    fsgr_ctl_t              ctl;
    logic [HANDLE_BITS-1:0] new_h;
    logic                   cv [GAP_DEPTH];
    logic [15:0]            cn [GAP_DEPTH];
    logic [HANDLE_BITS-1:0] ch [GAP_DEPTH];
    logic [31:0]            cs [GAP_DEPTH];
    logic [GAP_DEPTH-1:0]   mt;
    logic [GAP_DEPTH-1:0]   ps;

    logic            emit_ok;
    logic            do_emit;
    logic            do_flush;
    fsgr_out_t       res;
    logic [31:0]     age;
    logic            expired;
    logic [LW-1:0]   lim;
    logic [HANDLE_BITS-1:0] hit_h;
    logic [16:0]     tn17;

    assign new_h = HANDLE_BITS'({{HANDLE_BITS{1'b0}}, item_reg.msg_handle});

    genvar g;
    generate
        for (g = 0; g < GAP_DEPTH; g++)
        begin : g_cell
            logic                   lv, rv;
            logic [15:0]            ln, rn;
            logic [HANDLE_BITS-1:0] lh, rh;
            logic [31:0]            ls, rs;
            if (g == 0)
            begin : g_left0
                assign lv = 1'b1;
                assign ln = '0;
                assign lh = '0;
                assign ls = '0;
            end
            else
            begin : g_leftn
                assign lv = cv[g-1];
                assign ln = cn[g-1];
                assign lh = ch[g-1];
                assign ls = cs[g-1];
            end
            if (g == GAP_DEPTH - 1)
            begin : g_rightl
                assign rv = 1'b0;
                assign rn = '0;
                assign rh = '0;
                assign rs = '0;
            end
            else
            begin : g_rightn
                assign rv = cv[g+1];
                assign rn = cn[g+1];
                assign rh = ch[g+1];
                assign rs = cs[g+1];
            end
            fsgr_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_handle (new_h),
                .l_valid    (lv),
                .l_num      (ln),
                .l_handle   (lh),
                .l_stamp    (ls),
                .r_valid    (rv),
                .r_num      (rn),
                .r_handle   (rh),
                .r_stamp    (rs),
                .valid      (cv[g]),
                .num        (cn[g]),
                .handle     (ch[g]),
                .stamp      (cs[g]),
                .match      (mt[g]),
                .pos        (ps[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit_h = '0;
        for (int i = 0; i < GAP_DEPTH; i++)
        begin
            if (mt[i])
            begin
                hit_h = hit_h | ch[i];
            end
        end
    end

    always_comb
    begin
        tn17    = {1'b0, item_reg.tracking_number};
        age     = item_reg.now_time - cs[0];
        expired = cv[0] && (age > ttl_reg);
        emit_ok = !hold_valid_reg || !out_valid_reg || !out_stall;
        if (gap_limit_reg == 5'd0)
        begin
            lim = LW'(1);
        end
        else if (LW'(gap_limit_reg) > LW'(GAP_DEPTH))
        begin
            lim = LW'(GAP_DEPTH);
        end
        else
        begin
            lim = LW'(gap_limit_reg);
        end

        ctl        = '0;
        ctl.target = exp_reg;
        ctl.num    = item_reg.tracking_number;
        ctl.stamp  = item_reg.now_time;
        do_emit    = 1'b0;
        do_flush   = 1'b0;
        res        = '0;
        state_next = state_reg;
        exp_next   = exp_reg;
        count_next = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                if (expired)
                begin
                    if (emit_ok)
                    begin
                        do_emit    = 1'b1;
                        res        = '{KIND_EXPIRE, cn[0], 16'({16'b0, ch[0]}), 1'b0};
                        ctl.shl    = 1'b1;
                        ctl.all    = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (!item_reg.func)
                begin
                    state_next = S_MSG;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MSG:
            begin
                res = '{KIND_DELIVER, item_reg.tracking_number, 16'({16'b0, new_h}), 1'b0};
                if (item_reg.tracking_number == 16'd0)
                begin
                    if (emit_ok)
                    begin
                        do_emit    = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else if (tn17 < exp_reg)
                begin
                    res.kind = KIND_DUP;
                    if (emit_ok)
                    begin
                        do_emit    = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else if (tn17 > exp_reg)
                begin
                    if (LW'(count_reg) >= lim && count_reg != '0)
                    begin
                        res = '{KIND_EVICT, cn[0], 16'({16'b0, ch[0]}), 1'b0};
                        if (emit_ok)
                        begin
                            do_emit    = 1'b1;
                            ctl.shl    = 1'b1;
                            ctl.all    = 1'b1;
                            count_next = count_reg - CW'(1);
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else
                begin
                    if (emit_ok)
                    begin
                        do_emit    = 1'b1;
                        exp_next   = exp_reg + 17'd1;
                        state_next = S_DRAIN;
                    end
                end
            end
            S_INS:
            begin
                res = '{KIND_DUP, item_reg.tracking_number,
                        16'({16'b0, new_h}), 1'b0};
                if (|ps)
                begin
                    res.kind = KIND_HELD;
                end
                if (emit_ok)
                begin
                    do_emit    = 1'b1;
                    state_next = S_FIN;
                    if (|ps)
                    begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                if (|mt)
                begin
                    res = '{KIND_DELIVER, exp_reg[15:0], 16'({16'b0, hit_h}), 1'b0};
                    if (emit_ok)
                    begin
                        do_emit    = 1'b1;
                        ctl.shl    = 1'b1;
                        count_next = count_reg - CW'(1);
                        exp_next   = exp_reg + 17'd1;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    do_flush   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (do_emit)
        begin
            hold_valid_next = 1'b1;
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
        if (do_flush)
        begin
            hold_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            exp_reg        <= {1'b0, FIRST_EXP_RST};
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            gap_limit_reg  <= GAP_LIMIT_RST;
            ttl_reg        <= TTL_TICKS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we && cfg_index == CFG_FIRST_EXP)
            begin
                exp_reg <= {1'b0, cfg_data[15:0]};
            end
            else
            begin
                exp_reg <= exp_next;
            end
            if (cfg_we && cfg_index == CFG_GAP_LIMIT)
            begin
                gap_limit_reg <= cfg_data[4:0];
            end
            if (cfg_we && cfg_index == CFG_TTL_TICKS)
            begin
                ttl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_item;
        end
        if (do_emit)
        begin
            hold_reg <= res;
            if (hold_valid_reg)
            begin
                out_reg <= hold_reg;
            end
        end
        else if (do_flush)
        begin
            out_reg <= '{hold_reg.kind, hold_reg.out_number, hold_reg.out_handle, 1'b1};
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(GAP_DEPTH))
        else $error("held count beyond store depth");

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        !cv[0] |-> count_reg == '0)
        else $error("empty head cell while entries counted");

    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !hold_valid_reg)
        else $error("pending result left at item end");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.shl && ctl.ins))
        else $error("remove and insert in the same cycle");

endmodule
